@@ src/fmsr_pkg.sv @@
package fmsr_pkg;

   // Duty counter width of each channel.
   localparam int DUTY_BITS = 10;
   localparam logic [DUTY_BITS-1:0] DUTY_MAX = {DUTY_BITS{1'b1}};

   // Fixed widths of the interface fields.
   localparam int FIELD_DUTY_BITS = 10;
   localparam int LIMIT_BITS      = 10;
   localparam int STEP_BITS       = 8;
   localparam int AXIS_BITS       = 8;
   localparam int CMP_BITS = (DUTY_BITS > LIMIT_BITS) ? DUTY_BITS : LIMIT_BITS;

   localparam int NUM_LANES = 4;
   localparam int LANE_ROTATE = 0;
   localparam int LANE_LOAD   = 1;
   localparam int LANE_RIGHT  = 2;
   localparam int LANE_LEFT   = 3;

   localparam int REQ_DATA_BITS = 48;
   localparam int RSP_DATA_BITS = 48;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 10;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] REG_RAMP_STEP  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_AUX_LIMIT  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TIRE_LIMIT = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STICK_LOW  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STICK_HIGH = 3'd4;

   localparam logic [STEP_BITS-1:0]  RAMP_STEP_RESET  = 8'd48;
   localparam logic [LIMIT_BITS-1:0] AUX_LIMIT_RESET  = 10'd960;
   localparam logic [LIMIT_BITS-1:0] TIRE_LIMIT_RESET = 10'd1008;
   localparam logic [AXIS_BITS-1:0]  STICK_LOW_RESET  = 8'h0A;
   localparam logic [AXIS_BITS-1:0]  STICK_HIGH_RESET = 8'h77;
   localparam logic [AXIS_BITS-1:0]  STICK_FWD        = 8'h00;
   localparam logic [AXIS_BITS-1:0]  STICK_REV        = 8'h7f;

   // Button bit positions.
   localparam int BTN_SQUARE   = 0;
   localparam int BTN_L1       = 1;
   localparam int BTN_L2       = 2;
   localparam int BTN_R1       = 3;
   localparam int BTN_R2       = 4;
   localparam int BTN_TRIANGLE = 4;
   localparam int BTN_CIRCLE   = 6;

   // Channel command codes.
   localparam logic [1:0] CMD_NONE = 2'd0;
   localparam logic [1:0] CMD_FWD  = 2'd1;
   localparam logic [1:0] CMD_REV  = 2'd2;

   typedef struct packed {
      logic                  en;
      logic                  stop;
      logic [1:0]            cmd;
      logic [LIMIT_BITS-1:0] limit;
      logic [STEP_BITS-1:0]  step;
   } lane_ctl_type;

   typedef struct packed {
      logic [FIELD_DUTY_BITS-1:0] duty;
      logic                       dir;
   } lane_res_type;

   function automatic logic [FIELD_DUTY_BITS-1:0] to_field(input logic [DUTY_BITS-1:0] v);
      logic [CMP_BITS-1:0] t;
      t = CMP_BITS'(v);
      return t[FIELD_DUTY_BITS-1:0];
   endfunction

endpackage

@@ src/fmsr_lane.sv @@
module fmsr_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  fmsr_pkg::lane_ctl_type ctl,
   output fmsr_pkg::lane_res_type res
);

   logic [fmsr_pkg::DUTY_BITS-1:0] duty_ff, duty_in;
   logic [fmsr_pkg::DUTY_BITS-1:0] fwd_ff, fwd_in;
   logic [fmsr_pkg::DUTY_BITS-1:0] rev_ff, rev_in;
   logic [fmsr_pkg::DUTY_BITS-1:0] out_ff, out_in;
   logic                           dir_ff, dir_in;

   logic [fmsr_pkg::DUTY_BITS-1:0] shadow;
   logic [fmsr_pkg::DUTY_BITS-1:0] shadow_next;
   logic [fmsr_pkg::DUTY_BITS:0]   duty_sum;
   logic [fmsr_pkg::DUTY_BITS-1:0] duty_up;
   logic [fmsr_pkg::DUTY_BITS-1:0] duty_down;
   logic [fmsr_pkg::DUTY_BITS-1:0] step_ext;
   logic [fmsr_pkg::CMP_BITS-1:0]  duty_cmp;
   logic [fmsr_pkg::CMP_BITS-1:0]  limit_cmp;
   logic                           below_limit;

   assign shadow    = (ctl.cmd == fmsr_pkg::CMD_FWD) ? fwd_ff : rev_ff;
   assign step_ext  = fmsr_pkg::DUTY_BITS'(ctl.step);
   assign duty_sum  = {1'b0, duty_ff} + {1'b0, step_ext};
   assign duty_up   = duty_sum[fmsr_pkg::DUTY_BITS] ? fmsr_pkg::DUTY_MAX
                                                    : duty_sum[fmsr_pkg::DUTY_BITS-1:0];
   assign duty_down = (duty_ff > step_ext) ? duty_ff - step_ext : '0;
   assign duty_cmp  = fmsr_pkg::CMP_BITS'(duty_ff);
   assign limit_cmp = fmsr_pkg::CMP_BITS'(ctl.limit);
   assign below_limit = duty_cmp < limit_cmp;

   always_comb begin
      duty_in     = duty_ff;
      fwd_in      = fwd_ff;
      rev_in      = rev_ff;
      dir_in      = dir_ff;
      out_in      = ctl.stop ? '0 : out_ff;
      shadow_next = shadow;
      case (ctl.cmd)
         fmsr_pkg::CMD_NONE: begin
            if (duty_ff != '0) begin
               duty_in = duty_down;
               out_in  = duty_down;
            end
         end
         fmsr_pkg::CMD_FWD, fmsr_pkg::CMD_REV: begin
            // The shadow equals the duty in this branch, so it shares the ramp-up value.
            if (duty_ff == shadow) begin
               if (below_limit) begin
                  duty_in     = duty_up;
                  out_in      = duty_up;
                  dir_in      = (ctl.cmd == fmsr_pkg::CMD_FWD);
                  shadow_next = duty_up;
               end
            end else begin
               if (duty_ff != '0) begin
                  duty_in = duty_down;
                  out_in  = duty_down;
               end
               if (shadow > step_ext) begin
                  shadow_next = shadow - step_ext;
               end else begin
                  shadow_next = '0;
               end
            end
            if (ctl.cmd == fmsr_pkg::CMD_FWD) begin
               fwd_in = shadow_next;
            end else begin
               rev_in = shadow_next;
            end
         end
         default: begin
            duty_in = duty_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff <= '0;
         fwd_ff  <= '0;
         rev_ff  <= '0;
         out_ff  <= '0;
         dir_ff  <= 1'b0;
      end else if (ctl.en) begin
         duty_ff <= duty_in;
         fwd_ff  <= fwd_in;
         rev_ff  <= rev_in;
         out_ff  <= out_in;
         dir_ff  <= dir_in;
      end
   end

   assign res.duty = fmsr_pkg::to_field(out_in);
   assign res.dir  = dir_in;

endmodule

@@ src/fmsr_merge.sv @@
module fmsr_merge (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   input  fmsr_pkg::lane_res_type               lane_res [fmsr_pkg::NUM_LANES],
   input  logic                                 shooter,
   output logic                                 full,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [fmsr_pkg::RSP_DATA_BITS-1:0]   rsp_tdata
);

   logic [fmsr_pkg::RSP_DATA_BITS-1:0] beat;
   logic [fmsr_pkg::RSP_DATA_BITS-1:0] head_ff, head_in;
   logic [fmsr_pkg::RSP_DATA_BITS-1:0] skid_ff, skid_in;
   logic                               head_valid_ff, head_valid_in;
   logic                               skid_valid_ff, skid_valid_in;
   logic                               pop;

   assign beat = {3'b000, shooter,
                  lane_res[fmsr_pkg::LANE_LEFT].dir,
                  lane_res[fmsr_pkg::LANE_RIGHT].dir,
                  lane_res[fmsr_pkg::LANE_LOAD].dir,
                  lane_res[fmsr_pkg::LANE_ROTATE].dir,
                  lane_res[fmsr_pkg::LANE_LEFT].duty,
                  lane_res[fmsr_pkg::LANE_RIGHT].duty,
                  lane_res[fmsr_pkg::LANE_LOAD].duty,
                  lane_res[fmsr_pkg::LANE_ROTATE].duty};

   assign pop = head_valid_ff && rsp_tready;

   // Two-entry output queue: the skid entry lets a new beat in while the head one waits.
   always_comb begin
      head_in       = head_ff;
      skid_in       = skid_ff;
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (!head_valid_ff || pop) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            head_valid_in = 1'b1;
            skid_in       = beat;
            skid_valid_in = push;
         end else begin
            head_in       = beat;
            head_valid_in = push;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         skid_in       = beat;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign full       = skid_valid_ff;
   assign rsp_tvalid = head_valid_ff;
   assign rsp_tdata  = head_ff;

endmodule

@@ src/four_channel_motor_soft_ramp_core.sv @@
// Four-channel motor soft-start ramp. Each request beat is one decoded gamepad packet; each
// one yields exactly one response beat with the four PWM duties, the four direction bits and
// the shooter latch. The four channels (rotation, loading, right tire, left tire) run as
// parallel lanes that update in the cycle of acceptance, and a new packet can be taken every
// cycle while req_tready is high; a two-beat output queue keeps req_tready high while
// one response waits, and req_tready drops only when both entries are held. A reversal winds
// the duty down to zero before it ramps up the other way. Configuration registers (index 0
// ramp_step, 1 aux_limit, 2 tire_limit, 3 stick_low, 4 stick_high) are written through the
// csr_ port, which is always ready; writes to other indexes are ignored.
module four_channel_motor_soft_ramp_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // buttons_a[7:0], buttons_b[15:8], left_x[23:16], left_y[31:24],
   // right_x[39:32], right_y[47:40]
   input  logic [fmsr_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // duty_rotate[9:0], duty_load[19:10], duty_right[29:20], duty_left[39:30],
   // dir_rotate[40], dir_load[41], dir_right[42], dir_left[43], shooter[44], zero[47:45]
   output logic [fmsr_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [fmsr_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [fmsr_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   logic [fmsr_pkg::STEP_BITS-1:0]  ramp_step_ff;
   logic [fmsr_pkg::LIMIT_BITS-1:0] aux_limit_ff;
   logic [fmsr_pkg::LIMIT_BITS-1:0] tire_limit_ff;
   logic [fmsr_pkg::AXIS_BITS-1:0]  stick_low_ff;
   logic [fmsr_pkg::AXIS_BITS-1:0]  stick_high_ff;
   logic                            shooter_ff, shooter_in;

   logic [7:0] buttons_a, buttons_b, left_x, left_y, right_x, right_y;
   logic       accept;
   logic       full;
   logic [1:0] cmd [fmsr_pkg::NUM_LANES];

   fmsr_pkg::lane_ctl_type ctl      [fmsr_pkg::NUM_LANES];
   fmsr_pkg::lane_res_type lane_res [fmsr_pkg::NUM_LANES];

   assign buttons_a = req_tdata[7:0];
   assign buttons_b = req_tdata[15:8];
   assign left_x    = req_tdata[23:16];
   assign left_y    = req_tdata[31:24];
   assign right_x   = req_tdata[39:32];
   assign right_y   = req_tdata[47:40];

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   function automatic logic [1:0] stick_cmd(input logic [7:0] x, input logic [7:0] y,
                                            input logic [7:0] lo, input logic [7:0] hi);
      logic in_window;
      in_window = (x < hi) && (x > lo);
      if (in_window && (y == fmsr_pkg::STICK_FWD)) begin
         return fmsr_pkg::CMD_FWD;
      end else if (in_window && (y == fmsr_pkg::STICK_REV)) begin
         return fmsr_pkg::CMD_REV;
      end
      return fmsr_pkg::CMD_NONE;
   endfunction

   // The first direction wins when both buttons of a pair are held.
   assign cmd[fmsr_pkg::LANE_ROTATE] = buttons_a[fmsr_pkg::BTN_R1] ? fmsr_pkg::CMD_FWD :
                                       buttons_a[fmsr_pkg::BTN_R2] ? fmsr_pkg::CMD_REV :
                                                                     fmsr_pkg::CMD_NONE;
   assign cmd[fmsr_pkg::LANE_LOAD]   = buttons_a[fmsr_pkg::BTN_L1] ? fmsr_pkg::CMD_FWD :
                                       buttons_a[fmsr_pkg::BTN_L2] ? fmsr_pkg::CMD_REV :
                                                                     fmsr_pkg::CMD_NONE;
   assign cmd[fmsr_pkg::LANE_RIGHT]  = stick_cmd(right_x, right_y, stick_low_ff, stick_high_ff);
   assign cmd[fmsr_pkg::LANE_LEFT]   = stick_cmd(left_x, left_y, stick_low_ff, stick_high_ff);

   always_comb begin
      shooter_in = shooter_ff;
      if (buttons_b[fmsr_pkg::BTN_CIRCLE]) begin
         shooter_in = 1'b1;
      end
      if (buttons_b[fmsr_pkg::BTN_TRIANGLE]) begin
         shooter_in = 1'b0;
      end
   end

   for (genvar i = 0; i < fmsr_pkg::NUM_LANES; i++) begin : g_lane
      assign ctl[i].en    = accept;
      assign ctl[i].stop  = buttons_a[fmsr_pkg::BTN_SQUARE];
      assign ctl[i].cmd   = cmd[i];
      assign ctl[i].limit = (i == fmsr_pkg::LANE_RIGHT || i == fmsr_pkg::LANE_LEFT)
                            ? tire_limit_ff : aux_limit_ff;
      assign ctl[i].step  = ramp_step_ff;

      fmsr_lane u_lane (
         .clock (clock),
         .reset (reset),
         .ctl   (ctl[i]),
         .res   (lane_res[i])
      );
   end

   fmsr_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .lane_res   (lane_res),
      .shooter    (shooter_in),
      .full       (full),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         shooter_ff <= 1'b0;
      end else if (accept) begin
         shooter_ff <= shooter_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_step_ff  <= fmsr_pkg::RAMP_STEP_RESET;
         aux_limit_ff  <= fmsr_pkg::AUX_LIMIT_RESET;
         tire_limit_ff <= fmsr_pkg::TIRE_LIMIT_RESET;
         stick_low_ff  <= fmsr_pkg::STICK_LOW_RESET;
         stick_high_ff <= fmsr_pkg::STICK_HIGH_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            fmsr_pkg::REG_RAMP_STEP:  ramp_step_ff  <= csr_data[fmsr_pkg::STEP_BITS-1:0];
            fmsr_pkg::REG_AUX_LIMIT:  aux_limit_ff  <= csr_data[fmsr_pkg::LIMIT_BITS-1:0];
            fmsr_pkg::REG_TIRE_LIMIT: tire_limit_ff <= csr_data[fmsr_pkg::LIMIT_BITS-1:0];
            fmsr_pkg::REG_STICK_LOW:  stick_low_ff  <= csr_data[fmsr_pkg::AXIS_BITS-1:0];
            fmsr_pkg::REG_STICK_HIGH: stick_high_ff <= csr_data[fmsr_pkg::AXIS_BITS-1:0];
            default: begin
               ramp_step_ff <= ramp_step_ff;
            end
         endcase
      end
   end

endmodule

@@ tb/testbench.sv @@
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import fmsr_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int NUM_PHASES    = 9;
   localparam int RANDOM_ITEMS  = 180;
   localparam int LONG_HOLD     = 80;
   localparam int DIR_BASE      = NUM_LANES * FIELD_DUTY_BITS;
   localparam int SHOOTER_BIT   = DIR_BASE + NUM_LANES;

   localparam logic [1:0] CMD_BOTH = 2'd3;

   localparam logic [7:0] SQUARE_MASK   = 8'(1 << BTN_SQUARE);
   localparam logic [7:0] L1_MASK       = 8'(1 << BTN_L1);
   localparam logic [7:0] L2_MASK       = 8'(1 << BTN_L2);
   localparam logic [7:0] R1_MASK       = 8'(1 << BTN_R1);
   localparam logic [7:0] R2_MASK       = 8'(1 << BTN_R2);
   localparam logic [7:0] TRIANGLE_MASK = 8'(1 << BTN_TRIANGLE);
   localparam logic [7:0] CIRCLE_MASK   = 8'(1 << BTN_CIRCLE);

   class ramp_scoreboard;
      int step, aux_limit, tire_limit, stick_low, stick_high;
      int duty[NUM_LANES];
      int fwd_shadow[NUM_LANES];
      int rev_shadow[NUM_LANES];
      int out_duty[NUM_LANES];
      logic [NUM_LANES-1:0] dir_bits;
      logic shooter;
      logic [RSP_DATA_BITS-1:0] expected_beats[$];
      int mismatches;
      string lane_name[NUM_LANES] = '{"rotate", "load", "right", "left"};

      function new();
         step       = RAMP_STEP_RESET;
         aux_limit  = AUX_LIMIT_RESET;
         tire_limit = TIRE_LIMIT_RESET;
         stick_low  = STICK_LOW_RESET;
         stick_high = STICK_HIGH_RESET;
         for (int i = 0; i < NUM_LANES; i++) begin
            duty[i] = 0;
            fwd_shadow[i] = 0;
            rev_shadow[i] = 0;
            out_duty[i] = 0;
         end
         dir_bits = '0;
         shooter = 1'b0;
         mismatches = 0;
      endfunction

      function void set_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
         case (idx)
            REG_RAMP_STEP:  step       = val[STEP_BITS-1:0];
            REG_AUX_LIMIT:  aux_limit  = val[LIMIT_BITS-1:0];
            REG_TIRE_LIMIT: tire_limit = val[LIMIT_BITS-1:0];
            REG_STICK_LOW:  stick_low  = val[AXIS_BITS-1:0];
            REG_STICK_HIGH: stick_high = val[AXIS_BITS-1:0];
            default: ;
         endcase
      endfunction

      function int sat_up(int v);
         return (v + step > int'(DUTY_MAX)) ? int'(DUTY_MAX) : v + step;
      endfunction

      function int sat_down(int v);
         return (v > step) ? v - step : 0;
      endfunction

      function logic [1:0] button_cmd(logic first, logic second);
         return first ? CMD_FWD : (second ? CMD_REV : CMD_NONE);
      endfunction

      function logic [1:0] stick_cmd(int x, int y);
         logic in_window;
         in_window = (x < stick_high) && (x > stick_low);
         if (in_window && y == STICK_FWD) return CMD_FWD;
         if (in_window && y == STICK_REV) return CMD_REV;
         return CMD_NONE;
      endfunction

      // A command ramps up only while the duty tracks that direction's shadow;
      // otherwise both wind down, which is what makes a reversal pass through zero.
      function void ramp_lane(int lane, logic [1:0] cmd, int limit);
         int sh;
         if (cmd == CMD_NONE) begin
            if (duty[lane] > 0) begin
               duty[lane] = sat_down(duty[lane]);
               out_duty[lane] = duty[lane];
            end
            return;
         end
         sh = (cmd == CMD_FWD) ? fwd_shadow[lane] : rev_shadow[lane];
         if (duty[lane] == sh) begin
            if (duty[lane] < limit) begin
               duty[lane] = sat_up(duty[lane]);
               out_duty[lane] = duty[lane];
               dir_bits[lane] = (cmd == CMD_FWD);
            end
            if (sh < limit) sh = sat_up(sh);
         end else begin
            if (duty[lane] > 0) begin
               duty[lane] = sat_down(duty[lane]);
               out_duty[lane] = duty[lane];
            end
            if (sh > 0) sh = sat_down(sh);
         end
         if (cmd == CMD_FWD) fwd_shadow[lane] = sh;
         else rev_shadow[lane] = sh;
      endfunction

      function void note_packet(logic [REQ_DATA_BITS-1:0] d);
         logic [7:0] ba, bb, lx, ly, rx, ry;
         logic [RSP_DATA_BITS-1:0] want;
         {ry, rx, ly, lx, bb, ba} = d;
         if (ba[BTN_SQUARE])
            for (int i = 0; i < NUM_LANES; i++) out_duty[i] = 0;
         ramp_lane(LANE_ROTATE, button_cmd(ba[BTN_R1], ba[BTN_R2]), aux_limit);
         ramp_lane(LANE_LOAD, button_cmd(ba[BTN_L1], ba[BTN_L2]), aux_limit);
         if (bb[BTN_CIRCLE]) shooter = 1'b1;
         if (bb[BTN_TRIANGLE]) shooter = 1'b0;
         ramp_lane(LANE_RIGHT, stick_cmd(rx, ry), tire_limit);
         ramp_lane(LANE_LEFT, stick_cmd(lx, ly), tire_limit);
         want = '0;
         for (int i = 0; i < NUM_LANES; i++) begin
            want[i*FIELD_DUTY_BITS +: FIELD_DUTY_BITS] = FIELD_DUTY_BITS'(out_duty[i]);
            want[DIR_BASE + i] = dir_bits[i];
         end
         want[SHOOTER_BIT] = shooter;
         expected_beats.push_back(want);
      endfunction

      task report_mismatch(string what, int got, int want);
         $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
         mismatches++;
      endtask

      task check_beat(logic [RSP_DATA_BITS-1:0] got);
         logic [RSP_DATA_BITS-1:0] want;
         if (expected_beats.size() == 0) begin
            report_mismatch("response beat with nothing expected", 1, 0);
            return;
         end
         want = expected_beats.pop_front();
         for (int i = 0; i < NUM_LANES; i++) begin
            if (got[i*FIELD_DUTY_BITS +: FIELD_DUTY_BITS] !==
                want[i*FIELD_DUTY_BITS +: FIELD_DUTY_BITS])
               report_mismatch({"duty_", lane_name[i]},
                               got[i*FIELD_DUTY_BITS +: FIELD_DUTY_BITS],
                               want[i*FIELD_DUTY_BITS +: FIELD_DUTY_BITS]);
            if (got[DIR_BASE + i] !== want[DIR_BASE + i])
               report_mismatch({"dir_", lane_name[i]}, got[DIR_BASE + i], want[DIR_BASE + i]);
         end
         if (got[SHOOTER_BIT] !== want[SHOOTER_BIT])
            report_mismatch("shooter", got[SHOOTER_BIT], want[SHOOTER_BIT]);
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   ramp_scoreboard sb = new();

   int cycle_count = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int hold_left = 0;
   logic long_hold_req = 1'b0;
   logic [1:0] rotate_intent = CMD_NONE;
   logic [1:0] load_intent = CMD_NONE;
   logic [1:0] right_intent = CMD_NONE;
   logic [1:0] left_intent = CMD_NONE;

   // Register settings per phase: step, aux limit, tire limit, stick window.
   int phase_step[NUM_PHASES]  = '{255, 48, 1, 255, 7, 0, 128, 33, 20};
   int phase_aux[NUM_PHASES]   = '{960, 960, 1023, 0, 500, 960, 1023, 700, 100};
   int phase_tire[NUM_PHASES]  = '{1008, 1008, 1023, 0, 300, 1008, 17, 1023, 900};
   int phase_low[NUM_PHASES]   = '{10, 10, 0, 255, 100, 10, 0, 60, 200};
   int phase_high[NUM_PHASES]  = '{119, 119, 255, 0, 200, 119, 128, 61, 255};

   four_channel_motor_soft_ramp_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Receiver: random stalls, plus one long hold-off that lets the block back up.
   always @(posedge clock) begin
      if (long_hold_req) begin
         hold_left = LONG_HOLD;
         long_hold_req = 1'b0;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Handshake signals are stable between the falling edge and the next rising
   // edge, so beats are recognized here, ahead of the edge that moves them.
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_beat(rsp_tdata);
         if (req_tvalid && req_tready) sb.note_packet(req_tdata);
      end
   end

   function automatic logic [REQ_DATA_BITS-1:0] pack_packet(
      logic [7:0] ba, logic [7:0] bb, logic [7:0] lx, logic [7:0] ly,
      logic [7:0] rx, logic [7:0] ry);
      return {ry, rx, ly, lx, bb, ba};
   endfunction

   function automatic logic [1:0] pick_intent();
      int r;
      r = $urandom_range(99);
      if (r < 40) return CMD_FWD;
      if (r < 80) return CMD_REV;
      if (r < 90) return CMD_BOTH;
      return CMD_NONE;
   endfunction

   function automatic logic [7:0] button_bits(logic [1:0] intent, logic [7:0] first,
                                              logic [7:0] second);
      case (intent)
         CMD_FWD:  return first;
         CMD_REV:  return second;
         CMD_BOTH: return first | second;
         default:  return 8'h00;
      endcase
   endfunction

   function automatic logic [15:0] stick_axes(logic [1:0] intent);
      logic [7:0] x, y;
      int r;
      if (intent != CMD_FWD && intent != CMD_REV) begin
         r = $urandom_range(99);
         x = 8'($urandom);
         y = (r < 20) ? STICK_FWD : ((r < 40) ? STICK_REV : 8'($urandom));
         return {y, x};
      end
      r = $urandom_range(99);
      if (r < 5) x = 8'(sb.stick_low);
      else if (r < 10) x = 8'(sb.stick_high);
      else if (sb.stick_high > sb.stick_low + 1)
         x = 8'($urandom_range(sb.stick_high - 1, sb.stick_low + 1));
      else x = 8'($urandom);
      y = (intent == CMD_FWD) ? STICK_FWD : STICK_REV;
      return {y, x};
   endfunction

   // Mostly sustained commands so ramps reach their limits and reversals occur,
   // with a share of fully random packets as noise.
   function automatic logic [REQ_DATA_BITS-1:0] make_random_packet();
      logic [7:0] ba, bb;
      logic [15:0] left_axes, right_axes;
      if ($urandom_range(99) < 15) return REQ_DATA_BITS'({$urandom, $urandom});
      if ($urandom_range(99) < 8) rotate_intent = pick_intent();
      if ($urandom_range(99) < 8) load_intent = pick_intent();
      if ($urandom_range(99) < 8) right_intent = pick_intent();
      if ($urandom_range(99) < 8) left_intent = pick_intent();
      ba = 8'($urandom) & 8'hE0;
      if ($urandom_range(99) < 8) ba = ba | SQUARE_MASK;
      ba = ba | button_bits(rotate_intent, R1_MASK, R2_MASK);
      ba = ba | button_bits(load_intent, L1_MASK, L2_MASK);
      bb = 8'($urandom) & ~(CIRCLE_MASK | TRIANGLE_MASK);
      if ($urandom_range(99) < 10) bb = bb | CIRCLE_MASK;
      if ($urandom_range(99) < 6) bb = bb | TRIANGLE_MASK;
      left_axes = stick_axes(left_intent);
      right_axes = stick_axes(right_intent);
      return pack_packet(ba, bb, left_axes[7:0], left_axes[15:8],
                         right_axes[7:0], right_axes[15:8]);
   endfunction

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
      logic ok;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do begin
         @(negedge clock);
         ok = csr_ready;
         @(posedge clock);
      end while (!ok);
      sb.set_reg(idx, val);
   endtask

   task automatic send_packet(logic [REQ_DATA_BITS-1:0] d);
      logic ok;
      while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      do begin
         @(negedge clock);
         ok = req_tready;
         @(posedge clock);
      end while (!ok);
   endtask

   task automatic drain(int extra);
      while (sb.expected_beats.size() > 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   initial begin
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         sender_idle_pct = (phase % 4 == 1) ? 51 : ((phase % 4 == 3) ? 9 : 0);
         receiver_stall_pct = (phase % 4 == 2) ? 51 : ((phase % 4 == 3) ? 9 : 0);
         write_reg(REG_RAMP_STEP, CSR_DATA_BITS'(phase_step[phase]));
         write_reg(REG_AUX_LIMIT, CSR_DATA_BITS'(phase_aux[phase]));
         write_reg(REG_TIRE_LIMIT, CSR_DATA_BITS'(phase_tire[phase]));
         write_reg(REG_STICK_LOW, CSR_DATA_BITS'(phase_low[phase]));
         write_reg(REG_STICK_HIGH, CSR_DATA_BITS'(phase_high[phase]));
         csr_valid <= 1'b0;
         @(posedge clock);

         if (phase == 0) begin
            send_packet(pack_packet(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
            send_packet(pack_packet(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
            // Ramp up one way, then reverse: the duty must wind down first.
            repeat (4) send_packet(pack_packet(R1_MASK | L2_MASK, CIRCLE_MASK,
                                               8'd50, STICK_REV, 8'd50, STICK_FWD));
            repeat (3) send_packet(pack_packet(R2_MASK | L1_MASK, 8'h00,
                                               8'd50, STICK_FWD, 8'd50, STICK_REV));
            send_packet(pack_packet(R1_MASK | R2_MASK | L1_MASK | L2_MASK, TRIANGLE_MASK,
                                    8'd50, STICK_FWD, 8'd50, STICK_REV));
            send_packet(pack_packet(SQUARE_MASK | R1_MASK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
            send_packet(pack_packet(SQUARE_MASK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
            // Window edges are exclusive on both sides.
            send_packet(pack_packet(8'h00, CIRCLE_MASK | TRIANGLE_MASK,
                                    STICK_LOW_RESET, STICK_FWD, STICK_HIGH_RESET, STICK_FWD));
            send_packet(pack_packet(8'h00, 8'h00, STICK_LOW_RESET + 8'd1, STICK_FWD,
                                    STICK_HIGH_RESET - 8'd1, STICK_REV));
            send_packet(pack_packet(8'h00, 8'h00, 8'd50, 8'h01, 8'd50, 8'h7e));
            send_packet(pack_packet(8'hE0, 8'hAF, 8'hFF, 8'h80, 8'h00, 8'hFF));
         end

         for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase == 1 && n == 20) begin
               req_tvalid <= 1'b0;
               @(negedge clock);
               long_hold_req = 1'b1;
               @(posedge clock);
            end
            send_packet(make_random_packet());
         end
         req_tvalid <= 1'b0;
         @(posedge clock);
         drain(4);
      end

      drain(10);
      if (sb.expected_beats.size() > 0)
         sb.report_mismatch("response beats still expected at end",
                            0, sb.expected_beats.size());
      if (sb.mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/fmsr_pkg.sv
src/fmsr_lane.sv
src/fmsr_merge.sv
src/four_channel_motor_soft_ramp_core.sv
tb/testbench.sv
